// ----- src/upsc_pkg.sv -----
// Shared types and constants of the pixel replication upscaler.
package upsc_pkg;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_MAX_SCALE = 100;
  localparam int MAX_HEIGHT    = 4096;

  localparam int SCALE_W  = 7;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;
  localparam int ROW_W    = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int CHAN_W  = 8;
  localparam int PIXEL_W = 3 * CHAN_W;

  typedef enum logic [1:0] {
    ST_STORED       = 2'd0,
    ST_PIXEL        = 2'd1,
    ST_PULL_REFUSED = 2'd2,
    ST_PUSH_REFUSED = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE  = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } cfg_reg_t;

  localparam logic REQ_PUSH = 1'b0;

  typedef struct packed {
    status_t              status;
    logic                 row_end;
    logic [1:0]           pad_bytes;
    logic                 frame_end;
    logic [WIDTH_W-1:0]   col;
  } step_t;

endpackage

// ----- src/upsc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module upsc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/upsc_ctrl.sv -----
// Configuration registers, row and frame counters, and per-transfer decode.
module upsc_ctrl #(
  parameter int MAX_WIDTH = upsc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_SCALE = upsc_pkg::DEF_MAX_SCALE
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [upsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [upsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            accept,
  input  logic                            req_type,
  output upsc_pkg::step_t                 step
);
  import upsc_pkg::*;

  logic [SCALE_W-1:0]  scale_factor;
  logic [WIDTH_W-1:0]  source_width;
  logic [HEIGHT_W-1:0] source_height;

  logic [WIDTH_W-1:0] load_count;
  logic               row_ready;
  logic [WIDTH_W-1:0] read_column;
  logic [SCALE_W-1:0] across_count;
  logic [SCALE_W-1:0] down_count;
  logic [ROW_W-1:0]   source_row;

  logic [SCALE_W-1:0]  s_eff;
  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic                last_load;
  logic                last_across;
  logic                last_col;
  logic                last_down;
  logic                last_row;
  logic [3:0]          pad_prod;
  logic                is_push;

  always_comb begin
    if (scale_factor == '0) begin
      s_eff = SCALE_W'(1);
    end else if (32'(scale_factor) > MAX_SCALE) begin
      s_eff = SCALE_W'(MAX_SCALE);
    end else begin
      s_eff = scale_factor;
    end
    if (source_width == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (32'(source_width) > MAX_WIDTH) begin
      w_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      w_eff = source_width;
    end
    if (source_height == '0) begin
      h_eff = HEIGHT_W'(1);
    end else if (32'(source_height) > MAX_HEIGHT) begin
      h_eff = HEIGHT_W'(MAX_HEIGHT);
    end else begin
      h_eff = source_height;
    end
  end

  assign is_push     = (req_type == REQ_PUSH);
  assign last_load   = ({1'b0, load_count} + 1'b1) >= {1'b0, w_eff};
  assign last_across = ({1'b0, across_count} + 1'b1) >= {1'b0, s_eff};
  assign last_col    = ({1'b0, read_column} + 1'b1) >= {1'b0, w_eff};
  assign last_down   = ({1'b0, down_count} + 1'b1) >= {1'b0, s_eff};
  assign last_row    = ({1'b0, source_row} + 1'b1) >= h_eff;
  assign pad_prod    = 4'(w_eff[1:0]) * 4'(s_eff[1:0]);

  always_comb begin
    step           = '0;
    step.status    = ST_STORED;
    if (is_push) begin
      step.col    = load_count;
      step.status = row_ready ? ST_PUSH_REFUSED : ST_STORED;
    end else if (!row_ready) begin
      step.status = ST_PULL_REFUSED;
    end else begin
      step.status = ST_PIXEL;
      step.col    = read_column;
      if (last_across && last_col) begin
        step.row_end   = 1'b1;
        step.pad_bytes = pad_prod[1:0];
        step.frame_end = last_down && last_row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor  <= SCALE_W'(1);
      source_width  <= WIDTH_W'(1);
      source_height <= HEIGHT_W'(1);
      load_count    <= '0;
      row_ready     <= 1'b0;
      read_column   <= '0;
      across_count  <= '0;
      down_count    <= '0;
      source_row    <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SCALE:  scale_factor  <= cfg_wdata[SCALE_W-1:0];
        REG_WIDTH:  source_width  <= cfg_wdata[WIDTH_W-1:0];
        REG_HEIGHT: source_height <= cfg_wdata[HEIGHT_W-1:0];
        default: ;
      endcase
      if (cfg_index == REG_SCALE || cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT) begin
        load_count   <= '0;
        row_ready    <= 1'b0;
        read_column  <= '0;
        across_count <= '0;
        down_count   <= '0;
        source_row   <= '0;
      end
    end else if (accept) begin
      if (is_push) begin
        if (!row_ready) begin
          if (last_load) begin
            load_count   <= '0;
            row_ready    <= 1'b1;
            read_column  <= '0;
            across_count <= '0;
            down_count   <= '0;
          end else begin
            load_count <= load_count + 1'b1;
          end
        end
      end else if (row_ready) begin
        if (!last_across) begin
          across_count <= across_count + 1'b1;
        end else begin
          across_count <= '0;
          if (!last_col) begin
            read_column <= read_column + 1'b1;
          end else begin
            read_column <= '0;
            if (!last_down) begin
              down_count <= down_count + 1'b1;
            end else begin
              down_count <= '0;
              row_ready  <= 1'b0;
              source_row <= last_row ? '0 : source_row + 1'b1;
            end
          end
        end
      end
    end
  end

endmodule

// ----- src/pixel_replication_upscaler_top.sv -----
// Top level of the pixel replication upscaler: line buffer, decode and output pipeline.
//
// Pushes load one source row into the line buffer; pulls then emit each buffered pixel
// scale_factor times across and the whole row scale_factor times down, flagging the last
// pixel of each output row (with its pad byte count) and of the frame. Every transfer,
// push or pull, yields exactly one result. The block takes one transfer per cycle
// unless out_ready stalls a full output register and stage; each result passes
// through the registered line buffer read and then the output register. Writes to the
// scale, width or height register restart the frame and keep the buffer contents.
module pixel_replication_upscaler_top #(
  parameter int MAX_WIDTH = upsc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_SCALE = upsc_pkg::DEF_MAX_SCALE
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [upsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [upsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            req_type,
  input  logic [upsc_pkg::CHAN_W-1:0]     src_red,
  input  logic [upsc_pkg::CHAN_W-1:0]     src_green,
  input  logic [upsc_pkg::CHAN_W-1:0]     src_blue,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      status,
  output logic [upsc_pkg::CHAN_W-1:0]     out_red,
  output logic [upsc_pkg::CHAN_W-1:0]     out_green,
  output logic [upsc_pkg::CHAN_W-1:0]     out_blue,
  output logic                            row_end,
  output logic [1:0]                      pad_bytes,
  output logic                            frame_end
);
  import upsc_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  step_t              step;
  step_t              s1_step;
  logic               s1_valid;
  logic               s1_adv;
  logic               accept;
  logic               ram_we;
  logic               ram_re;
  logic [PIXEL_W-1:0] ram_rdata;
  logic [PIXEL_W-1:0] pixel;

  assign in_ready = !s1_valid || !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign ram_we   = accept && (step.status == ST_STORED);
  assign ram_re   = accept && (step.status == ST_PIXEL);

  upsc_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .req_type  (req_type),
    .step      (step)
  );

  upsc_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(step.col)),
    .wdata ({src_red, src_green, src_blue}),
    .re    (ram_re),
    .raddr (AW'(step.col)),
    .rdata (ram_rdata)
  );

  assign pixel = (s1_step.status == ST_PIXEL) ? ram_rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_step <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      status    <= s1_step.status;
      out_red   <= pixel[3*CHAN_W-1:2*CHAN_W];
      out_green <= pixel[2*CHAN_W-1:CHAN_W];
      out_blue  <= pixel[CHAN_W-1:0];
      row_end   <= s1_step.row_end;
      pad_bytes <= s1_step.pad_bytes;
      frame_end <= s1_step.frame_end;
    end
  end

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_PIXEL) |->
      (out_red == '0 && out_green == '0 && out_blue == '0 && !row_end &&
       pad_bytes == '0 && !frame_end))
    else $error("non-pixel result carries pixel fields");

  a_frame_on_row: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |-> row_end)
    else $error("frame end without row end");

  a_rdata_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> $stable(ram_rdata))
    else $error("line buffer read data changed under a held stage");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_step)))
    else $error("held stage dropped or changed");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |-> !in_ready)
    else $error("input taken while stage is blocked");

endmodule
